[sv/abme_pkg.sv]
// Package of the adjacency bit-matrix engine: item types, codes and constants.
`default_nettype none
package abme_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int CMP_W            = 9;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_TEST     = 3'd1;
    localparam logic [2:0] OP_LIST     = 3'd2;
    localparam logic [2:0] OP_DEGREE   = 3'd3;
    localparam logic [2:0] OP_IN_DEG   = 3'd4;
    localparam logic [2:0] OP_OUT_DEG  = 3'd5;

    localparam logic REG_IS_DIRECTED  = 1'b0;
    localparam logic REG_VERTEX_COUNT = 1'b1;

    localparam logic [6:0]  VERTEX_COUNT_RST = 7'd64;
    localparam logic [15:0] EDGE_TOTAL_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] src_vertex;
        logic [5:0] dst_vertex;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  value;
        logic        valid_value;
        logic        last;
        logic        status;
        logic [15:0] edge_total;
    } t_out_item;

    typedef struct packed {
        logic       is_directed;
        logic [6:0] vertex_count;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_MIRROR,
        ST_SCAN,
        ST_SWEEP
    } t_state;

endpackage
`default_nettype wire

[sv/adjacency_bit_matrix_engine.sv]
// Top level of the adjacency bit-matrix engine: sequencer around the edge-row memory.
//
//  Channel   Handshake               Payload       Direction
//  command   start, busy             i_item        in
//  result    o_valid (strobe)        o_result      out
//  config    psel, penable, pready   paddr/pwdata  in, prdata out
//
// An out-of-range or unknown command gives its result in the next cycle and keeps busy low.
// Add writes the source row in ST_ROW and, when undirected with two distinct vertices, the
// mirror row in ST_MIRROR; test answers from ST_ROW. Neighbour lists scan the row bits in
// order in ST_SCAN up to the highest set one; an empty list gives a single final result.
// Degree counts sweep every vertex in use in ST_SWEEP: the single memory read port
// delivers one row a cycle. Reset clears per-row valid bits at once, so no clearing pass runs.
// Results are shown for one cycle and cannot be stalled.
`default_nettype none
module adjacency_bit_matrix_engine #(
    parameter int MAX_VERTICES = abme_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire abme_pkg::t_in_item            i_item,
    output logic                               o_valid,
    output abme_pkg::t_out_item                o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [abme_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [abme_pkg::PDATA_W-1:0]  pwdata,
    output logic      [abme_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);
    import abme_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    function automatic logic [VW-1:0] to_idx(input logic [5:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        return w[VW-1:0];
    endfunction

    function automatic t_out_item make_res(input logic [7:0] value, input logic vv,
                                           input logic last, input logic status,
                                           input logic [15:0] total);
        t_out_item res;
        res.value       = value;
        res.valid_value = vv;
        res.last        = last;
        res.status      = status;
        res.edge_total  = total;
        return res;
    endfunction

    t_cfg cfg;

    abme_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_state                r_state, n_state;
    logic [2:0]            r_op, n_op;
    logic [5:0]            r_src, n_src;
    logic [5:0]            r_dst, n_dst;
    logic [MAX_VERTICES-1:0] r_scan, n_scan;
    logic [VW-1:0]         r_idx, n_idx;
    logic [7:0]            r_cnt, n_cnt;
    logic [15:0]           r_edge_total, n_edge_total;
    logic [MAX_VERTICES-1:0] r_row_valid, n_row_valid;
    logic                  r_rd_ok;
    t_out_item             r_res, n_res;
    logic                  r_res_vld, n_res_vld;

    logic                    ram_we;
    logic [VW-1:0]           ram_waddr;
    logic [MAX_VERTICES-1:0] ram_wdata;
    logic [VW-1:0]           ram_raddr;
    logic [MAX_VERTICES-1:0] ram_rdata;
    logic [MAX_VERTICES-1:0] row_data;
    logic [MAX_VERTICES-1:0] act_mask;
    logic [CW-1:0]           n_eff;
    logic                    accept;
    logic                    in_err;
    logic                    scan_last;
    logic                    sweep_last;
    logic                    col_bit;

    abme_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign row_data = r_rd_ok ? ram_rdata : '0;
    assign col_bit  = row_data[to_idx(r_src)];

    always_comb begin
        if (CMP_W'(cfg.vertex_count) > CMP_W'(MAX_VERTICES)) begin
            n_eff = CW'(MAX_VERTICES);
        end else begin
            n_eff = CW'(cfg.vertex_count);
        end
        for (int i = 0; i < MAX_VERTICES; i++) begin
            act_mask[i] = (CMP_W'(i) < CMP_W'(n_eff));
        end
    end

    assign in_err = (i_item.op > OP_OUT_DEG)
                 || (CMP_W'(i_item.src_vertex) >= CMP_W'(n_eff))
                 || (((i_item.op == OP_ADD) || (i_item.op == OP_TEST))
                     && (CMP_W'(i_item.dst_vertex) >= CMP_W'(n_eff)));

    assign scan_last  = (r_scan == '0) || (r_scan[0] && (r_scan[MAX_VERTICES-1:1] == '0));
    assign sweep_last = ((CMP_W'(r_idx) + CMP_W'(1)) == CMP_W'(n_eff));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !in_err) begin
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                unique case (r_op)
                    OP_ADD: begin
                        if (!cfg.is_directed && (r_dst != r_src)) begin
                            n_state = ST_MIRROR;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    OP_TEST: n_state = ST_IDLE;
                    OP_LIST: n_state = ST_SCAN;
                    default: n_state = ST_SWEEP;
                endcase
            end
            ST_MIRROR: n_state = ST_IDLE;
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_op         = r_op;
        n_src        = r_src;
        n_dst        = r_dst;
        n_scan       = r_scan;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_edge_total = r_edge_total;
        n_row_valid  = r_row_valid;
        n_res        = r_res;
        n_res_vld    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = to_idx(r_src);
        ram_wdata    = row_data;
        ram_raddr    = to_idx(i_item.src_vertex);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op  = i_item.op;
                    n_src = i_item.src_vertex;
                    n_dst = i_item.dst_vertex;
                    if (in_err) begin
                        n_res_vld = 1'b1;
                        n_res     = make_res(8'd0, 1'b0, 1'b1, 1'b1, r_edge_total);
                    end
                end
            end
            ST_ROW: begin
                unique case (r_op)
                    OP_ADD: begin
                        ram_we    = 1'b1;
                        ram_waddr = to_idx(r_src);
                        ram_wdata = row_data | (MAX_VERTICES'(1) << to_idx(r_dst));
                        n_row_valid[to_idx(r_src)] = 1'b1;
                        ram_raddr = to_idx(r_dst);
                        if (r_edge_total != EDGE_TOTAL_MAX) begin
                            n_edge_total = r_edge_total + 16'd1;
                        end
                        if (cfg.is_directed || (r_dst == r_src)) begin
                            n_res_vld = 1'b1;
                            n_res     = make_res(8'd0, 1'b0, 1'b1, 1'b0, n_edge_total);
                        end
                    end
                    OP_TEST: begin
                        n_res_vld = 1'b1;
                        n_res     = make_res(8'(row_data[to_idx(r_dst)]), 1'b1, 1'b1,
                                             1'b0, r_edge_total);
                    end
                    OP_LIST: begin
                        n_scan = row_data & act_mask;
                        n_idx  = '0;
                    end
                    default: begin
                        n_scan    = row_data & act_mask;
                        n_idx     = '0;
                        n_cnt     = 8'd0;
                        ram_raddr = '0;
                    end
                endcase
            end
            ST_MIRROR: begin
                ram_we    = 1'b1;
                ram_waddr = to_idx(r_dst);
                ram_wdata = row_data | (MAX_VERTICES'(1) << to_idx(r_src));
                n_row_valid[to_idx(r_dst)] = 1'b1;
                n_res_vld = 1'b1;
                n_res     = make_res(8'd0, 1'b0, 1'b1, 1'b0, r_edge_total);
            end
            ST_SCAN: begin
                if (r_scan == '0) begin
                    n_res_vld = 1'b1;
                    n_res     = make_res(8'd0, 1'b0, 1'b1, 1'b0, r_edge_total);
                end else if (r_scan[0]) begin
                    n_res_vld = 1'b1;
                    n_res     = make_res(8'(r_idx), 1'b1, scan_last, 1'b0, r_edge_total);
                end
                n_scan = r_scan >> 1;
                n_idx  = r_idx + VW'(1);
            end
            ST_SWEEP: begin
                n_cnt = r_cnt + 8'((r_op != OP_IN_DEG) && r_scan[0])
                              + 8'((r_op != OP_OUT_DEG) && col_bit);
                n_scan    = r_scan >> 1;
                n_idx     = r_idx + VW'(1);
                ram_raddr = r_idx + VW'(1);
                if (sweep_last) begin
                    n_res_vld = 1'b1;
                    n_res     = make_res(n_cnt, 1'b1, 1'b1, 1'b0, r_edge_total);
                end
            end
            default: begin
                n_res_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_edge_total <= '0;
            r_row_valid  <= '0;
            r_res_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_edge_total <= n_edge_total;
            r_row_valid  <= n_row_valid;
            r_res_vld    <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_scan  <= n_scan;
        r_idx   <= n_idx;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
        r_rd_ok <= r_row_valid[ram_raddr];
    end

    assign o_valid  = r_res_vld;
    assign o_result = r_res;

`ifndef SYNTH
    a_res_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past((r_state != ST_IDLE) || (start && !busy)))
        else $error("Result without a command in progress.");

    a_counter_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_edge_total != $past(r_edge_total))
        |-> (r_edge_total == 16'($past(r_edge_total) + 16'd1)))
        else $error("Edge counter moved by other than one.");

    a_write_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (((r_state == ST_ROW) && (r_op == OP_ADD)) || (r_state == ST_MIRROR)))
        else $error("Edge memory written outside an add.");

    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |-> $past(busy))
        else $error("Non-final result from a finished item.");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status) |-> (o_result.last && !o_result.valid_value))
        else $error("Error result not final or marked valid.");
`endif

endmodule
`default_nettype wire

[sv/abme_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module abme_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/abme_cfg.sv]
// Configuration registers of the adjacency bit-matrix engine behind an APB-style port.
`default_nettype none
module abme_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [abme_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [abme_pkg::PDATA_W-1:0]  pwdata,
    output logic      [abme_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output abme_pkg::t_cfg                     o_cfg
);
    import abme_pkg::*;

    logic       r_is_directed;
    logic [6:0] r_vertex_count;
    logic       reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[PADDR_W-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_directed  <= 1'b0;
            r_vertex_count <= VERTEX_COUNT_RST;
        end else if (wr_en) begin
            if (reg_idx == REG_IS_DIRECTED) begin
                r_is_directed <= pwdata[0];
            end else begin
                r_vertex_count <= pwdata[6:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == REG_VERTEX_COUNT) begin
            prdata = PDATA_W'(r_vertex_count);
        end else begin
            prdata = PDATA_W'(r_is_directed);
        end
    end

    assign o_cfg.is_directed  = r_is_directed;
    assign o_cfg.vertex_count = r_vertex_count;

endmodule
`default_nettype wire

[bench/tb_adjacency_bit_matrix_engine.sv]
// Self-checking bench for the adjacency bit-matrix engine: directed and random runs.
module tb_adjacency_bit_matrix_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import abme_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES   = 80;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 16;

    class edge_matrix_scoreboard;
        bit [63:0] adj_rows [64];
        bit [15:0] edge_total;
        bit        directed;
        bit [6:0]  vcount;
        t_out_item awaited_results [$];
        int        mismatches;
        int        results_checked;
        int        rejected;
        int        op_hits [8];

        function new();
            edge_total = '0;
            directed = 1'b0;
            vcount = VERTEX_COUNT_RST;
            mismatches = 0;
            results_checked = 0;
            rejected = 0;
            foreach (op_hits[i]) op_hits[i] = 0;
            foreach (adj_rows[i]) adj_rows[i] = '0;
        endfunction

        function int unsigned active_count();
            return (vcount > 64) ? 64 : vcount;
        endfunction

        function void set_register(logic idx, logic [31:0] data);
            if (idx == REG_IS_DIRECTED) begin
                directed = data[0];
            end else begin
                vcount = data[6:0];
            end
        endfunction

        function logic [31:0] register_value(logic idx);
            return (idx == REG_IS_DIRECTED) ? 32'(directed) : 32'(vcount);
        endfunction

        function void queue_result(int unsigned value, bit valid, bit last, bit status);
            t_out_item r;
            r.value = 8'(value);
            r.valid_value = valid;
            r.last = last;
            r.status = status;
            r.edge_total = edge_total;
            awaited_results = {awaited_results, r};
        endfunction

        function void note_command(t_in_item cmd);
            int unsigned n;
            int top;
            int cnt;
            n = active_count();
            op_hits[cmd.op]++;
            if (cmd.op > OP_OUT_DEG || cmd.src_vertex >= n ||
                ((cmd.op == OP_ADD || cmd.op == OP_TEST) && cmd.dst_vertex >= n)) begin
                rejected++;
                queue_result(0, 1'b0, 1'b1, 1'b1);
                return;
            end
            case (cmd.op)
                OP_ADD: begin
                    adj_rows[cmd.src_vertex][cmd.dst_vertex] = 1'b1;
                    if (!directed) adj_rows[cmd.dst_vertex][cmd.src_vertex] = 1'b1;
                    if (edge_total != EDGE_TOTAL_MAX) edge_total++;
                    queue_result(0, 1'b0, 1'b1, 1'b0);
                end
                OP_TEST: begin
                    queue_result(adj_rows[cmd.src_vertex][cmd.dst_vertex], 1'b1, 1'b1, 1'b0);
                end
                OP_LIST: begin
                    top = -1;
                    for (int i = 0; i < n; i++) begin
                        if (adj_rows[cmd.src_vertex][i]) top = i;
                    end
                    if (top < 0) begin
                        queue_result(0, 1'b0, 1'b1, 1'b0);
                    end else begin
                        for (int i = 0; i <= top; i++) begin
                            if (adj_rows[cmd.src_vertex][i]) queue_result(i, 1'b1, i == top, 1'b0);
                        end
                    end
                end
                default: begin
                    cnt = 0;
                    for (int i = 0; i < n; i++) begin
                        if (cmd.op != OP_IN_DEG && adj_rows[cmd.src_vertex][i]) cnt++;
                        if (cmd.op != OP_OUT_DEG && adj_rows[i][cmd.src_vertex]) cnt++;
                    end
                    queue_result(cnt, 1'b1, 1'b1, 1'b0);
                end
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            results_checked++;
            if (awaited_results.size() == 0) begin
                $error("result with none awaited: value %0d, last %0b, status %0b",
                       got.value, got.last, got.status);
                mismatches++;
                return;
            end
            exp = awaited_results.pop_front();
            if (got.value !== exp.value) begin
                $error("value: expected %0d, got %0d", exp.value, got.value);
                mismatches++;
            end
            if (got.valid_value !== exp.valid_value) begin
                $error("valid_value: expected %0b, got %0b", exp.valid_value, got.valid_value);
                mismatches++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0b, got %0b", exp.last, got.last);
                mismatches++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0b, got %0b", exp.status, got.status);
                mismatches++;
            end
            if (got.edge_total !== exp.edge_total) begin
                $error("edge_total: expected %0d, got %0d", exp.edge_total, got.edge_total);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_item             i_item;
    logic                 o_valid;
    t_out_item            o_result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    edge_matrix_scoreboard matrix_sb = new();

    adjacency_bit_matrix_engine uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #1ms;
        $display("FAIL adjacency_bit_matrix_engine");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            matrix_sb.check_result(o_result);
        end
    end

    task automatic send_command(input t_in_item cmd, input int gap, input bit drain);
        if (drain || gap > 0) begin
            start <= 1'b0;
            @(posedge i_clk);
            while (drain && matrix_sb.awaited_results.size() != 0) @(posedge i_clk);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        matrix_sb.note_command(cmd);
    endtask

    task automatic issue(input logic [2:0] op, input logic [5:0] src, input logic [5:0] dst);
        t_in_item cmd;
        cmd.op = op;
        cmd.src_vertex = src;
        cmd.dst_vertex = dst;
        send_command(cmd, $urandom_range(0, 11), 1'b0);
    endtask

    task automatic settle_block();
        start <= 1'b0;
        @(posedge i_clk);
        while (matrix_sb.awaited_results.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] data);
        settle_block();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        matrix_sb.set_register(idx, data);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== matrix_sb.register_value(idx)) begin
            $error("prdata: expected %0d, got %0d", matrix_sb.register_value(idx), prdata);
            matrix_sb.mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [5:0] pick_vertex(int unsigned n);
        if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, n - 1));
    endfunction

    function automatic logic [2:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) return OP_ADD;
        if (r < 50) return OP_TEST;
        if (r < 62) return OP_LIST;
        if (r < 72) return OP_DEGREE;
        if (r < 80) return OP_IN_DEG;
        if (r < 88) return OP_OUT_DEG;
        if (r < 94) return OP_SPARE_LO;
        return OP_SPARE_HI;
    endfunction

    function automatic logic [6:0] phase_vertex_count(int p);
        case (p)
            0: return 7'd64;
            1: return 7'd8;
            2: return 7'd127;
            3: return 7'($urandom_range(1, 64));
            4: return 7'd3;
            default: return 7'($urandom_range(1, 16));
        endcase
    endfunction

    initial begin
        t_in_item cmd;
        int unsigned n;
        bit burst;

        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_register(REG_IS_DIRECTED, 32'd0);
        write_register(REG_VERTEX_COUNT, 32'd64);
        issue(OP_TEST, 6'd0, 6'd0);
        issue(OP_LIST, 6'd5, 6'd0);
        issue(OP_DEGREE, 6'd63, 6'd0);
        issue(OP_ADD, 6'd0, 6'd63);
        issue(OP_ADD, 6'd63, 6'd63);
        issue(OP_ADD, 6'd0, 6'd63);
        issue(OP_TEST, 6'd63, 6'd0);
        issue(OP_LIST, 6'd0, 6'd0);
        issue(OP_LIST, 6'd63, 6'd0);
        issue(OP_DEGREE, 6'd63, 6'd63);
        issue(OP_IN_DEG, 6'd63, 6'd0);
        issue(OP_OUT_DEG, 6'd0, 6'd0);
        issue(OP_SPARE_LO, 6'd0, 6'd0);
        issue(OP_SPARE_HI, 6'd63, 6'd63);

        write_register(REG_IS_DIRECTED, 32'd1);
        write_register(REG_VERTEX_COUNT, 32'd1);
        issue(OP_ADD, 6'd0, 6'd0);
        issue(OP_ADD, 6'd1, 6'd0);
        issue(OP_TEST, 6'd0, 6'd63);
        issue(OP_DEGREE, 6'd0, 6'd63);
        issue(OP_LIST, 6'd0, 6'd42);
        issue(OP_IN_DEG, 6'd63, 6'd0);

        write_register(REG_VERTEX_COUNT, 32'd0);
        issue(OP_TEST, 6'd0, 6'd0);
        issue(OP_OUT_DEG, 6'd0, 6'd0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_register(REG_IS_DIRECTED, 32'($urandom_range(0, 1)));
            write_register(REG_VERTEX_COUNT, 32'(phase_vertex_count(p)));
            n = matrix_sb.active_count();
            burst = (p % 2 == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                cmd.op = pick_op();
                cmd.src_vertex = pick_vertex(n);
                cmd.dst_vertex = pick_vertex(n);
                send_command(cmd, burst ? 0 : $urandom_range(0, 11),
                             p == 2 && k == PHASE_ITEMS / 2);
            end
        end

        write_register(REG_IS_DIRECTED, 32'd1);
        write_register(REG_VERTEX_COUNT, 32'd64);
        issue(OP_ADD, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        issue(OP_DEGREE, 6'($urandom_range(0, 63)), 6'd0);
        issue(OP_LIST, 6'($urandom_range(0, 63)), 6'd0);
        issue(OP_SPARE_HI, 6'd0, 6'd0);

        settle_block();
        $display("Run covered %0d adds, %0d tests, %0d neighbour lists, %0d degree queries",
                 matrix_sb.op_hits[OP_ADD], matrix_sb.op_hits[OP_TEST],
                 matrix_sb.op_hits[OP_LIST],
                 matrix_sb.op_hits[OP_DEGREE] + matrix_sb.op_hits[OP_IN_DEG] +
                 matrix_sb.op_hits[OP_OUT_DEG]);
        $display("%0d rejected commands, %0d results checked, edge counter ended at %0d",
                 matrix_sb.rejected, matrix_sb.results_checked, matrix_sb.edge_total);
        if (matrix_sb.mismatches == 0 && matrix_sb.awaited_results.size() == 0) begin
            $display("PASS adjacency_bit_matrix_engine");
        end else begin
            $display("FAIL adjacency_bit_matrix_engine");
        end
        $finish;
    end

endmodule
